### rtl/brb_pkg.sv
// Shared types, constants and pointer helpers for the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

  // Ring geometry: DEPTH slots, at most DEPTH-1 bytes held
  localparam int DEPTH      = 64;
  localparam int PUSH_LANES = 8;
  localparam int PTR_W      = $clog2(DEPTH);

  // Field widths of the beats
  localparam int OP_W    = 3;
  localparam int BYTES_W = 64;
  localparam int LANE_W  = 3;
  localparam int CNT_W   = 6;
  localparam int BYTE_W  = 8;

  localparam int IN_TDATA_W  = 72;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 16;
  localparam int OUT_TUSER_W = 2;

  // Operation codes carried on in_tuser
  typedef enum logic [OP_W-1:0] {
    OP_PUSH         = 3'd0,
    OP_PUSH_DISCARD = 3'd1,
    OP_POP          = 3'd2,
    OP_DROP         = 3'd3,
    OP_PEEK         = 3'd4,
    OP_CLEAR        = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WRITE,
    ST_READ,
    ST_EMIT,
    ST_RESP
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the input beat
    logic setup;      // apply pointer moves and load the byte counter
    logic wr_byte;    // write one pushed byte
    logic rd_req;     // read the byte at the scan pointer
    logic emit_byte;  // load a data beat into the output register
    logic emit_resp;  // load a data-less beat into the output register
    logic resp_err;   // status bit of the data-less beat
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    op_t  op;
    logic refuse;    // operation refused: count above the lane count, unknown code, or lack of space or data
    logic no_work;   // nothing to write or emit
    logic rem_one;   // one byte left to move
    logic out_free;  // output register can take a beat
  } stat_t;

  // (p + n) mod DEPTH, n below DEPTH
  function automatic logic [PTR_W-1:0] ptr_add(logic [PTR_W-1:0] p, logic [PTR_W-1:0] n);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, n};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

  // (w - r) mod DEPTH
  function automatic logic [PTR_W-1:0] ptr_diff(logic [PTR_W-1:0] w, logic [PTR_W-1:0] r);
    logic [PTR_W:0] s;
    s = {1'b0, w} + (PTR_W+1)'(DEPTH) - {1'b0, r};
    if (s >= (PTR_W+1)'(DEPTH)) begin
      s = s - (PTR_W+1)'(DEPTH);
    end
    return s[PTR_W-1:0];
  endfunction

endpackage

### rtl/brb_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module brb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/brb_ctrl.sv
// Sequencer of the byte ring buffer: one operation at a time.
`timescale 1ns / 1ps

module brb_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  brb_pkg::stat_t st,
  output brb_pkg::cmd_t  cmd
);

  brb_pkg::state_t state_r, state_nxt;
  logic            err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= brb_pkg::ST_IDLE;
      err_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = brb_pkg::ST_DECIDE;
        end
      end
      brb_pkg::ST_DECIDE: begin
        err_nxt = st.refuse;
        if (st.refuse || st.no_work) begin
          state_nxt = brb_pkg::ST_RESP;
        end else begin
          case (st.op)
            brb_pkg::OP_PUSH, brb_pkg::OP_PUSH_DISCARD: state_nxt = brb_pkg::ST_WRITE;
            brb_pkg::OP_POP, brb_pkg::OP_PEEK:          state_nxt = brb_pkg::ST_READ;
            default:                                    state_nxt = brb_pkg::ST_RESP;
          endcase
        end
      end
      brb_pkg::ST_WRITE: begin
        if (st.rem_one) begin
          state_nxt = brb_pkg::ST_RESP;
        end
      end
      brb_pkg::ST_READ: begin
        state_nxt = brb_pkg::ST_EMIT;
      end
      brb_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_nxt = st.rem_one ? brb_pkg::ST_IDLE : brb_pkg::ST_READ;
        end
      end
      brb_pkg::ST_RESP: begin
        if (st.out_free) begin
          state_nxt = brb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = brb_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      brb_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      brb_pkg::ST_DECIDE: begin
        cmd.setup = !st.refuse;
      end
      brb_pkg::ST_WRITE: begin
        cmd.wr_byte = 1'b1;
      end
      brb_pkg::ST_READ: begin
        cmd.rd_req = 1'b1;
      end
      brb_pkg::ST_EMIT: begin
        cmd.emit_byte = st.out_free;
      end
      brb_pkg::ST_RESP: begin
        cmd.emit_resp = st.out_free;
        cmd.resp_err  = err_r;
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/brb_dp.sv
// Datapath: operand registers, ring pointers, byte store and output register.
`timescale 1ns / 1ps

module brb_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  brb_pkg::cmd_t                cmd,
  output brb_pkg::stat_t               st,
  input  logic [brb_pkg::OP_W-1:0]     operation,
  input  logic [brb_pkg::BYTES_W-1:0]  push_bytes,
  input  logic [brb_pkg::CNT_W-1:0]    count,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [brb_pkg::BYTE_W-1:0]   data_byte,
  output logic                         has_data,
  output logic                         status,
  output logic                         last,
  output logic [brb_pkg::CNT_W-1:0]    fill_level
);

  localparam int PW = brb_pkg::PTR_W;
  localparam int CW = brb_pkg::CNT_W;

  // operand registers
  logic [brb_pkg::OP_W-1:0]    op_r;
  logic [brb_pkg::BYTES_W-1:0] bytes_r;
  logic [CW-1:0]               cnt_r;

  // ring state and work counters
  logic [PW-1:0]               rp_r, wp_r, scan_r;
  logic [CW-1:0]               rem_r;
  logic [brb_pkg::LANE_W-1:0]  lane_r;

  // output register
  logic                        ovalid_r;
  logic [brb_pkg::BYTE_W-1:0]  odata_r;
  logic                        ohas_r, ostat_r, olast_r;
  logic [CW-1:0]               ofill_r;

  logic [PW-1:0]               fill_p;
  logic [CW-1:0]               fill_c, cnt_eff, room;
  logic [CW:0]                 push_sum;
  logic                        cnt_over, push_full, cnt_gt_fill, need_discard;
  logic                        out_free;
  logic [brb_pkg::BYTE_W-1:0]  ram_rdata, wr_byte;
  brb_pkg::op_t                op;

  assign op     = brb_pkg::op_t'(op_r);
  assign fill_p = brb_pkg::ptr_diff(wp_r, rp_r);
  assign fill_c = CW'(fill_p);

  // space and data checks
  assign cnt_over     = cnt_r > CW'(brb_pkg::PUSH_LANES);
  assign push_sum     = {1'b0, cnt_r} + {1'b0, fill_c};
  assign push_full    = push_sum >= (CW+1)'(brb_pkg::DEPTH);
  assign cnt_gt_fill  = cnt_r > fill_c;
  assign cnt_eff      = (cnt_r > CW'(brb_pkg::DEPTH - 1)) ? CW'(brb_pkg::DEPTH - 1) : cnt_r;
  assign room         = CW'(brb_pkg::DEPTH - 1) - fill_c;
  assign need_discard = cnt_eff > room;

  assign out_free = !ovalid_r || out_ready;

  always_comb begin
    st.op       = op;
    st.rem_one  = rem_r == CW'(1);
    st.out_free = out_free;
    st.refuse   = 1'b1;
    st.no_work  = 1'b1;
    case (op)
      brb_pkg::OP_PUSH: begin
        st.refuse  = cnt_over || push_full;
        st.no_work = cnt_r == '0;
      end
      brb_pkg::OP_PUSH_DISCARD: begin
        st.refuse  = cnt_over;
        st.no_work = cnt_eff == '0;
      end
      brb_pkg::OP_POP: begin
        st.refuse  = cnt_gt_fill;
        st.no_work = cnt_r == '0;
      end
      brb_pkg::OP_DROP: begin
        st.refuse  = cnt_gt_fill;
      end
      brb_pkg::OP_PEEK: begin
        st.refuse  = 1'b0;
        st.no_work = fill_c == '0;
      end
      brb_pkg::OP_CLEAR: begin
        st.refuse  = 1'b0;
      end
      default: begin
        st.refuse  = 1'b1;
        st.no_work = 1'b1;
      end
    endcase
  end

  // input beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= operation;
      bytes_r <= push_bytes;
      cnt_r   <= count;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rp_r <= '0;
      wp_r <= '0;
    end else begin
      if (cmd.setup) begin
        case (op)
          brb_pkg::OP_PUSH_DISCARD: begin
            if (need_discard) begin
              rp_r <= brb_pkg::ptr_add(rp_r, PW'(cnt_eff - room));
            end
          end
          brb_pkg::OP_DROP: rp_r <= brb_pkg::ptr_add(rp_r, PW'(cnt_r));
          brb_pkg::OP_CLEAR: begin
            rp_r <= '0;
            wp_r <= '0;
          end
          default: ;
        endcase
      end
      if (cmd.wr_byte) begin
        wp_r <= brb_pkg::ptr_add(wp_r, PW'(1));
      end
      if (cmd.emit_byte && op == brb_pkg::OP_POP) begin
        rp_r <= brb_pkg::ptr_add(scan_r, PW'(1));
      end
    end
  end

  // work counters and scan pointer
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      lane_r <= '0;
      scan_r <= rp_r;
      case (op)
        brb_pkg::OP_PUSH_DISCARD: rem_r <= cnt_eff;
        brb_pkg::OP_PEEK:         rem_r <= fill_c;
        default:                  rem_r <= cnt_r;
      endcase
    end
    if (cmd.wr_byte) begin
      lane_r <= lane_r + brb_pkg::LANE_W'(1);
      rem_r  <= rem_r - CW'(1);
    end
    if (cmd.emit_byte) begin
      scan_r <= brb_pkg::ptr_add(scan_r, PW'(1));
      rem_r  <= rem_r - CW'(1);
    end
  end

  assign wr_byte = bytes_r[{lane_r, 3'b000} +: brb_pkg::BYTE_W];

  brb_ram #(
    .WIDTH (brb_pkg::BYTE_W),
    .DEPTH (brb_pkg::DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_byte),
    .wr_addr (wp_r),
    .wr_data (wr_byte),
    .rd_en   (cmd.rd_req),
    .rd_addr (scan_r),
    .rd_data (ram_rdata)
  );

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (cmd.emit_byte || cmd.emit_resp) begin
      ovalid_r <= 1'b1;
    end else if (out_ready) begin
      ovalid_r <= 1'b0;
    end
  end

  // output register payload; a pop beat shows the level after its byte leaves
  always_ff @(posedge clk) begin
    if (cmd.emit_byte) begin
      odata_r <= ram_rdata;
      ohas_r  <= 1'b1;
      ostat_r <= 1'b0;
      olast_r <= rem_r == CW'(1);
      ofill_r <= (op == brb_pkg::OP_POP) ? fill_c - CW'(1) : fill_c;
    end else if (cmd.emit_resp) begin
      odata_r <= '0;
      ohas_r  <= 1'b0;
      ostat_r <= cmd.resp_err;
      olast_r <= 1'b1;
      ofill_r <= fill_c;
    end
  end

  assign out_valid  = ovalid_r;
  assign data_byte  = odata_r;
  assign has_data   = ohas_r;
  assign status     = ostat_r;
  assign last       = olast_r;
  assign fill_level = ofill_r;

endmodule

### rtl/byte_ring_buffer_core.sv
// Top level of the byte ring buffer: stream ports, sequencer and datapath.
`timescale 1ns / 1ps

//  Channel | Dir | Ports                         | Contents
//  in      | in  | in_tvalid/tready/tdata/tuser  | one operation beat
//  out     | out | out_tvalid/tready/tdata/tuser/tlast | result beats
//
//  Push writes its bytes through one store write port, one byte a cycle.
//  Pop and peek do a registered store read for each byte before it is emitted.
//  The output register lets the next beat in while the last result waits;
//  a stalled out_tready holds the sequencer at the next result.
//  rst_n is synchronous, active low; it empties the ring, store contents stay.

module byte_ring_buffer_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [63:0] push_bytes, [69:64] count, [71:70] zero
  input  logic [brb_pkg::IN_TDATA_W-1:0]   in_tdata,
  // [2:0] operation
  input  logic [brb_pkg::IN_TUSER_W-1:0]   in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [7:0] data_byte, [13:8] fill_level, [15:14] zero
  output logic [brb_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [0] has_data, [1] status
  output logic [brb_pkg::OUT_TUSER_W-1:0]  out_tuser,
  output logic                             out_tlast
);

  brb_pkg::cmd_t               cmd;
  brb_pkg::stat_t              st;
  logic [brb_pkg::BYTE_W-1:0]  data_byte;
  logic [brb_pkg::CNT_W-1:0]   fill_level;
  logic                        has_data, status;

  brb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .st       (st),
    .cmd      (cmd)
  );

  brb_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .st         (st),
    .operation  (in_tuser[2:0]),
    .push_bytes (in_tdata[63:0]),
    .count      (in_tdata[69:64]),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .data_byte  (data_byte),
    .has_data   (has_data),
    .status     (status),
    .last       (out_tlast),
    .fill_level (fill_level)
  );

  assign out_tdata = {2'b00, fill_level, data_byte};
  assign out_tuser = {status, has_data};

`ifndef SYNTHESIS
  // one operation at a time: the beat after an accept is never taken
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an operation is in progress");

  // beats without a stored byte close their operation and carry a zero byte
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tlast && out_tdata[7:0] == 8'd0))
    else $error("data-less beat not last or not zero");

  // a refused operation never carries data
  a_refuse_nodata: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> !out_tuser[0])
    else $error("refused beat carries data");

  // a waiting result beat stays put until it is taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)))
    else $error("result beat changed while waiting");
`endif

endmodule
